>>> design/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

  // Input mode codes.
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_DATA   = 3'd2;
  localparam logic [2:0] MODE_CHAR   = 3'd3;
  localparam logic [2:0] MODE_CURSOR = 3'd4;

  // Expander control bits.
  localparam logic [7:0] BIT_BL = 8'b00001000;
  localparam logic [7:0] BIT_EN = 8'b00000100;
  localparam logic [7:0] BIT_RS = 8'b00000001;

  localparam logic [7:0]  CHAR_MIN      = 8'h30;
  localparam logic [7:0]  SET_DDRAM     = 8'h80;
  localparam logic [16:0] POWER_ON_WAIT = 17'd100000;
  localparam logic [6:0]  ADDR_RESET    = 7'd39;

  // Step counts of one transfer, counted from zero.
  localparam int          STEP_W         = 5;
  localparam logic [4:0]  LAST_STEP_INIT = 5'd23;
  localparam logic [4:0]  LAST_STEP_BYTE = 5'd3;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       emit;
    logic       init;
    logic [4:0] step;
    logic       last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic has_out;
    logic is_init;
    logic out_busy;
  } sts_t;

  // DDRAM base address of each display line.
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Nibble (in bits 3..0) sent at a given step of the init sequence.
  function automatic logic [3:0] init_nibble(input logic [4:0] step);
    logic [7:0] c;
    logic [3:0] n;
    unique case (step[4:2])
      3'd2: c = 8'h28;
      3'd3: c = 8'h0C;
      3'd4: c = 8'h01;
      default: c = 8'h06;
    endcase
    if (step < 5'd6) begin
      n = 4'h3;
    end else if (step < 5'd8) begin
      n = 4'h2;
    end else if (step[1] == 1'b0) begin
      n = c[7:4];
    end else begin
      n = c[3:0];
    end
    return n;
  endfunction

  // Settle time added after a given step of the init sequence.
  function automatic logic [15:0] init_settle(input logic [4:0] step);
    logic [15:0] s;
    unique case (step)
      5'd1:  s = 16'd5000;
      5'd3:  s = 16'd200;
      5'd5:  s = 16'd100;
      5'd7:  s = 16'd100;
      5'd11: s = 16'd100;
      5'd15: s = 16'd100;
      5'd19: s = 16'd5000;
      5'd23: s = 16'd5000;
      default: s = 16'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/clcd_ctrl.sv
`timescale 1ns / 1ps

module clcd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  clcd_pkg::sts_t sts,
  output clcd_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                          state_r, state_nxt;
  logic [clcd_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          init_r, init_nxt;
  logic                          accept;
  logic                          advance;
  logic                          last_step;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign advance   = (state_r == ST_EMIT) && !sts.out_busy;
  assign last_step = init_r ? (step_r == clcd_pkg::LAST_STEP_INIT)
                            : (step_r == clcd_pkg::LAST_STEP_BYTE);

  // Commands for the datapath.
  always_comb begin
    cmd.load = accept;
    cmd.emit = advance;
    cmd.init = init_r;
    cmd.step = step_r;
    cmd.last = last_step;
  end

  // Sequencer: one byte per cycle while the output register is free.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    init_nxt  = init_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && sts.has_out) begin
          state_nxt = ST_EMIT;
          step_nxt  = '0;
          init_nxt  = sts.is_init;
        end
      end
      default: begin
        if (advance) begin
          if (last_step) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      init_r  <= init_nxt;
    end
  end

endmodule

>>> design/clcd_dp.sv
`timescale 1ns / 1ps

module clcd_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [6:0]     cfg_device_address,
  input  logic [2:0]     in_mode,
  input  logic [7:0]     in_value,
  input  logic [5:0]     in_column,
  input  logic [1:0]     in_row,
  input  logic [15:0]    in_settle_us,
  input  clcd_pkg::cmd_t cmd,
  output clcd_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_bus_address,
  output logic [7:0]     out_expander_byte,
  output logic [16:0]    out_wait_before_us,
  output logic [16:0]    out_wait_after_us,
  output logic           out_last
);

  logic [6:0]  addr_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        rs_r, rs_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic        out_valid_r;
  logic [7:0]  ob_r;
  logic [16:0] before_r;
  logic [16:0] after_r;
  logic        last_r;
  logic [3:0]  nib;
  logic [15:0] settle_cur;
  logic [7:0]  eb;
  logic        char_ok;

  assign cfg_ready = 1'b1;

  // Device address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= clcd_pkg::ADDR_RESET;
    end else if (cfg_valid) begin
      addr_r <= cfg_device_address;
    end
  end

  // Decode of the incoming item.
  assign char_ok     = (in_value >= clcd_pkg::CHAR_MIN);
  assign sts.is_init = (in_mode == clcd_pkg::MODE_INIT);
  assign sts.has_out = (in_mode == clcd_pkg::MODE_INIT) || (in_mode == clcd_pkg::MODE_CMD) ||
                       (in_mode == clcd_pkg::MODE_DATA) || (in_mode == clcd_pkg::MODE_CURSOR) ||
                       ((in_mode == clcd_pkg::MODE_CHAR) && char_ok);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_comb begin
    byte_nxt   = in_value;
    rs_nxt     = 1'b0;
    settle_nxt = '0;
    unique case (in_mode)
      clcd_pkg::MODE_CMD: settle_nxt = in_settle_us;
      clcd_pkg::MODE_DATA, clcd_pkg::MODE_CHAR: rs_nxt = 1'b1;
      clcd_pkg::MODE_CURSOR: byte_nxt = clcd_pkg::SET_DDRAM + clcd_pkg::row_base(in_row)
                                        + {2'b00, in_column};
      default: ;
    endcase
  end

  // Item registers, loaded when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r   <= byte_nxt;
      rs_r     <= rs_nxt;
      settle_r <= settle_nxt;
    end
  end

  // Byte for the current step.
  always_comb begin
    if (cmd.init) begin
      nib        = clcd_pkg::init_nibble(cmd.step);
      settle_cur = clcd_pkg::init_settle(cmd.step);
    end else begin
      nib        = cmd.step[1] ? byte_r[3:0] : byte_r[7:4];
      settle_cur = cmd.last ? settle_r : 16'd0;
    end
    eb = {nib, 4'b0000} | clcd_pkg::BIT_BL;
    if (!cmd.step[0]) begin
      eb = eb | clcd_pkg::BIT_EN;
    end
    if (!cmd.init && rs_r) begin
      eb = eb | clcd_pkg::BIT_RS;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ob_r     <= eb;
      before_r <= (cmd.init && (cmd.step == '0)) ? clcd_pkg::POWER_ON_WAIT : 17'd0;
      after_r  <= {1'b0, settle_cur} + 17'd1;
      last_r   <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_address    = addr_r;
  assign out_expander_byte  = ob_r;
  assign out_wait_before_us = before_r;
  assign out_wait_after_us  = after_r;
  assign out_last           = last_r;

endmodule

>>> design/char_lcd_i2c_nibble_sequencer_top.sv
`timescale 1ns / 1ps

// Character-LCD sequencer for a 4-bit controller behind an I2C port expander.
// Each input transaction is one LCD operation (init, command, data, filtered
// character, set cursor); the block answers with the expander bytes for it, one
// output transaction per byte, the final one flagged by out_last. Command, data
// and cursor operations give 4 bytes, init gives 24, a filtered character below
// 0x30 and an unused mode give none. Bytes leave at one per cycle while out_ready
// is high. The next item is taken as soon as the last byte of the current one
// sits in the output register. The device address is written through the cfg
// port; the user is to write it only while the block is idle, which the block
// itself does not enforce.
module char_lcd_i2c_nibble_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_device_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic [15:0] in_settle_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_bus_address,
  output logic [7:0]  out_expander_byte,
  output logic [16:0] out_wait_before_us,
  output logic [16:0] out_wait_after_us,
  output logic        out_last
);

  clcd_pkg::cmd_t cmd;
  clcd_pkg::sts_t sts;

  // Controller: accepts items and steps through the bytes.
  clcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: item registers, byte formatting and output register.
  clcd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_settle_us       (in_settle_us),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bus_address    (out_bus_address),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule

>>> verif/lcd_sequence_checker.sv
`timescale 1ns / 1ps

// Watches the operation, result and address-write channels of the LCD sequencer,
// predicts the expander writes for every accepted operation and compares each
// accepted write against the oldest prediction.
module lcd_sequence_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_device_address,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic [15:0] in_settle_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  out_bus_address,
  input  logic [7:0]  out_expander_byte,
  input  logic [16:0] out_wait_before_us,
  input  logic [16:0] out_wait_after_us,
  input  logic        out_last,
  output int          mismatch_count,
  output int          bytes_pending
);

  // Bytes of the power-up sequence.
  localparam logic [7:0] INIT_WAKE        = 8'h30;
  localparam logic [7:0] INIT_FOUR_BIT    = 8'h20;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  // DDRAM address at which each display line starts.
  localparam logic [7:0] LINE_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  typedef struct packed {
    logic [6:0]  bus_address;
    logic [7:0]  expander_byte;
    logic [16:0] wait_before_us;
    logic [16:0] wait_after_us;
    logic        last;
  } expander_write_t;

  expander_write_t expected_writes[$];
  logic [6:0]      lcd_address = clcd_pkg::ADDR_RESET;
  int              mismatches = 0;

  function automatic void push_write(input logic [7:0] xbyte, input logic [16:0] wait_pre,
                                     input logic [16:0] wait_post);
    expander_write_t w;
    w.bus_address    = lcd_address;
    w.expander_byte  = xbyte;
    w.wait_before_us = wait_pre;
    w.wait_after_us  = wait_post;
    w.last           = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // One nibble (bits 7..4 of nib) as an enable-high then enable-low pair.
  function automatic void push_nibble(input logic [7:0] nib, input logic rs,
                                      input logic [16:0] wait_pre, input logic [15:0] settle);
    logic [7:0] xbyte;
    xbyte = (nib & 8'hF0) | clcd_pkg::BIT_BL | (rs ? clcd_pkg::BIT_RS : 8'h00);
    push_write(xbyte | clcd_pkg::BIT_EN, wait_pre, 17'd1);
    push_write(xbyte, 17'd0, 17'd1 + settle);
  endfunction

  // Full byte: high nibble first, settle time only after the low nibble.
  function automatic void push_full_byte(input logic [7:0] val, input logic rs,
                                         input logic [15:0] settle);
    push_nibble(val, rs, 17'd0, 16'd0);
    push_nibble({val[3:0], 4'h0}, rs, 17'd0, settle);
  endfunction

  function automatic void predict_operation(input logic [2:0] mode, input logic [7:0] value,
                                            input logic [5:0] column, input logic [1:0] row,
                                            input logic [15:0] settle);
    int              queued;
    expander_write_t tail;
    queued = expected_writes.size();
    case (mode)
      clcd_pkg::MODE_INIT: begin
        // Power-on wait, three wake-ups, switch to 4-bit, then the setup commands.
        push_nibble(INIT_WAKE, 1'b0, clcd_pkg::POWER_ON_WAIT, 16'd5000);
        push_nibble(INIT_WAKE, 1'b0, 17'd0, 16'd200);
        push_nibble(INIT_WAKE, 1'b0, 17'd0, 16'd100);
        push_nibble(INIT_FOUR_BIT, 1'b0, 17'd0, 16'd100);
        push_full_byte(CMD_FUNCTION_SET, 1'b0, 16'd100);
        push_full_byte(CMD_DISPLAY_ON, 1'b0, 16'd100);
        push_full_byte(CMD_CLEAR, 1'b0, 16'd5000);
        push_full_byte(CMD_ENTRY_MODE, 1'b0, 16'd5000);
      end
      clcd_pkg::MODE_CMD:  push_full_byte(value, 1'b0, settle);
      clcd_pkg::MODE_DATA: push_full_byte(value, 1'b1, 16'd0);
      clcd_pkg::MODE_CHAR: begin
        // Control codes below the filter threshold produce nothing.
        if (value >= clcd_pkg::CHAR_MIN) begin
          push_full_byte(value, 1'b1, 16'd0);
        end
      end
      clcd_pkg::MODE_CURSOR: begin
        push_full_byte(clcd_pkg::SET_DDRAM + LINE_START[row] + {2'b00, column}, 1'b0, 16'd0);
      end
      default: ;
    endcase
    if (expected_writes.size() > queued) begin
      tail = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
    end
  endfunction

  // Predictions are queued before the compare so that a same-edge write finds its entry.
  always @(posedge clk) begin
    expander_write_t want;
    expander_write_t got;
    if (!rst_n) begin
      expected_writes.delete();
      lcd_address = clcd_pkg::ADDR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lcd_address = cfg_device_address;
      end
      if (in_valid && in_ready) begin
        predict_operation(in_mode, in_value, in_column, in_row, in_settle_us);
      end
      if (out_valid && out_ready) begin
        got = '{out_bus_address, out_expander_byte, out_wait_before_us,
                out_wait_after_us, out_last};
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected expander write: addr=%h byte=%h", $time,
                     got.bus_address, got.expander_byte);
          end
        end else begin
          want = expected_writes.pop_front();
          if (got.bus_address !== want.bus_address ||
              got.expander_byte !== want.expander_byte ||
              got.wait_before_us !== want.wait_before_us ||
              got.wait_after_us !== want.wait_after_us ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] expander write mismatch: expected addr=%h byte=%h %s",
                       $time, want.bus_address, want.expander_byte,
                       $sformatf("pre=%0d post=%0d last=%b", want.wait_before_us,
                                 want.wait_after_us, want.last));
              $display("[%0t]   got addr=%h byte=%h pre=%0d post=%0d last=%b",
                       $time, got.bus_address, got.expander_byte, got.wait_before_us,
                       got.wait_after_us, got.last);
            end
          end
        end
      end
    end
    bytes_pending  <= expected_writes.size();
    mismatch_count <= mismatches;
  end

endmodule

>>> verif/char_lcd_i2c_nibble_sequencer_top_tb.sv
`timescale 1ns / 1ps

module char_lcd_i2c_nibble_sequencer_top_tb;

  // Mode values the block does not decode.
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int         QUIET_LIMIT       = 2000;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_EVERY_THIRD, RX_LONG_STALLS} rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_device_address;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [7:0]  in_value;
  logic [5:0]  in_column;
  logic [1:0]  in_row;
  logic [15:0] in_settle_us;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_bus_address;
  logic [7:0]  out_expander_byte;
  logic [16:0] out_wait_before_us;
  logic [16:0] out_wait_after_us;
  logic        out_last;

  int          mismatch_count;
  int          bytes_pending;
  int          burst_left;
  logic        sender_active;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_lcd_i2c_nibble_sequencer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_settle_us       (in_settle_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bus_address    (out_bus_address),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

  lcd_sequence_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .in_settle_us       (in_settle_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bus_address    (out_bus_address),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .bytes_pending      (bytes_pending)
  );

  // Receiver: switches between randomly chosen stall patterns.
  rx_style_t   rx_style = RX_STREAM;
  int          style_left = 0;
  int          hold_left = 0;
  logic [2:0]  rotor = 3'b001;

  always @(posedge clk) begin
    if (style_left == 0) begin
      rx_style   <= rx_style_t'($urandom_range(0, 3));
      style_left <= $urandom_range(40, 200);
    end else begin
      style_left <= style_left - 1;
    end
    rotor <= {rotor[1:0], rotor[2]};
    case (rx_style)
      RX_STREAM:      out_ready <= 1'b1;
      RX_RANDOM:      out_ready <= ($urandom_range(0, 3) != 0);
      RX_EVERY_THIRD: out_ready <= rotor[0];
      default: begin
        if (hold_left != 0) begin
          hold_left <= hold_left - 1;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left <= $urandom_range(3, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: ends the run when no transaction moves on any channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one operation and holds it until accepted; valid stays up inside a burst.
  task automatic send_op(input logic [2:0] mode, input logic [7:0] value,
                         input logic [5:0] column, input logic [1:0] row,
                         input logic [15:0] settle);
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_value     <= value;
    in_column    <= column;
    in_row       <= row;
    in_settle_us <= settle;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (burst_left > 1) begin
      burst_left--;
      sender_active = 1'b1;
    end else begin
      in_valid <= 1'b0;
      sender_active = 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    if (sender_active) begin
      in_valid <= 1'b0;
      sender_active = 1'b0;
    end
  endtask

  // Waits until every expected write has arrived, then lets a no-output item finish.
  task automatic wait_drained();
    do @(posedge clk); while (bytes_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_device_address(input logic [6:0] addr);
    wait_drained();
    cfg_valid          <= 1'b1;
    cfg_device_address <= addr;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Random operations, mostly decoded modes; unused modes do not count.
  task automatic run_random_ops(input int count);
    int          sent;
    int          pick;
    logic [2:0]  mode;
    logic [5:0]  column;
    logic [15:0] settle;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       mode = clcd_pkg::MODE_INIT;
      else if (pick < 30) mode = clcd_pkg::MODE_CMD;
      else if (pick < 55) mode = clcd_pkg::MODE_DATA;
      else if (pick < 75) mode = clcd_pkg::MODE_CHAR;
      else if (pick < 95) mode = clcd_pkg::MODE_CURSOR;
      else                mode = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                           : 6'($urandom_range(0, 39));
      case ($urandom_range(0, 3))
        0:       settle = 16'h0000;
        1:       settle = 16'hFFFF;
        default: settle = 16'($urandom_range(0, 65535));
      endcase
      send_op(mode, 8'($urandom_range(0, 255)), column, 2'($urandom_range(0, 3)), settle);
      if (mode <= clcd_pkg::MODE_CURSOR) begin
        sent++;
      end
    end
    end_burst();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_device_address = '0;
    in_valid           = 1'b0;
    in_mode            = clcd_pkg::MODE_INIT;
    in_value           = '0;
    in_column          = '0;
    in_row             = '0;
    in_settle_us       = '0;
    sender_active      = 1'b0;
    burst_left         = 4;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed operations at the reset address: extremes, filter edge, all lines.
    send_op(clcd_pkg::MODE_INIT, 8'h00, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CMD, 8'h00, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CMD, 8'hFF, 6'd63, 2'd3, 16'hFFFF);
    send_op(clcd_pkg::MODE_CMD, 8'hA5, 6'd0, 2'd0, 16'd1);
    send_op(clcd_pkg::MODE_DATA, 8'h00, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_DATA, 8'hFF, 6'd0, 2'd0, 16'hFFFF);
    send_op(clcd_pkg::MODE_DATA, 8'h5A, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CHAR, 8'h2F, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CHAR, 8'h30, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CHAR, 8'h00, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CHAR, 8'hFF, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CURSOR, 8'h00, 6'd0, 2'd0, 16'h0000);
    send_op(clcd_pkg::MODE_CURSOR, 8'h00, 6'd39, 2'd1, 16'h0000);
    send_op(clcd_pkg::MODE_CURSOR, 8'h00, 6'd20, 2'd2, 16'h0000);
    send_op(clcd_pkg::MODE_CURSOR, 8'h00, 6'd39, 2'd3, 16'h0000);
    // Columns past the display width; on the last line the DDRAM command byte wraps.
    send_op(clcd_pkg::MODE_CURSOR, 8'hFF, 6'd63, 2'd3, 16'hFFFF);
    send_op(clcd_pkg::MODE_CURSOR, 8'h00, 6'd63, 2'd1, 16'h0000);
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
      send_op(3'(m), 8'hFF, 6'd63, 2'd3, 16'hFFFF);
    end
    send_op(clcd_pkg::MODE_DATA, 8'h41, 6'd0, 2'd0, 16'h0000);
    end_burst();

    // Random phases, each after a write of the device address.
    write_device_address(7'h7F);
    run_random_ops(32);
    write_device_address(7'h00);
    run_random_ops(32);
    write_device_address(7'($urandom_range(1, 126)));
    run_random_ops(32);
    write_device_address(clcd_pkg::ADDR_RESET);
    run_random_ops(32);

    wait_drained();
    repeat (32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
